// ----- rtl/sbtc_pkg.sv -----
// Shared types, constants and pattern functions for the sieve byte tuplet counter.
`default_nettype none

package sbtc_pkg;

   localparam int TOTAL_BITS = 48;
   localparam int NUM_TOTALS = 6;
   localparam int MAX_MASKS  = 4;
   localparam int INCR_BITS  = 4;
   localparam int ENABLE_BITS = NUM_TOTALS;

   localparam logic [ENABLE_BITS-1:0] ENABLE_RESET = 6'h3f;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam int TOTAL_PRIME      = 0;
   localparam int TOTAL_TWIN       = 1;
   localparam int TOTAL_TRIPLET    = 2;
   localparam int TOTAL_QUADRUPLET = 3;
   localparam int TOTAL_QUINTUPLET = 4;
   localparam int TOTAL_SEXTUPLET  = 5;

   localparam logic [7:0] TUPLET_MASKS [NUM_TOTALS][MAX_MASKS] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h06, 8'h18, 8'hc0, 8'h00},
      '{8'h07, 8'h0e, 8'h1c, 8'h38},
      '{8'h1e, 8'h00, 8'h00, 8'h00},
      '{8'h1f, 8'h3e, 8'h00, 8'h00},
      '{8'h3f, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] TUPLET_MASK_COUNT [NUM_TOTALS] = '{
      3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd1
   };

   typedef logic [TOTAL_BITS-1:0] total_type;
   typedef logic [NUM_TOTALS-1:0][INCR_BITS-1:0] sbtc_incr_type;

   typedef struct packed {
      logic       command;
      logic [7:0] sieve_byte;
   } sbtc_req_type;

   typedef struct packed {
      total_type prime_total;
      total_type twin_total;
      total_type triplet_total;
      total_type quadruplet_total;
      total_type quintuplet_total;
      total_type sextuplet_total;
   } sbtc_rsp_type;

   function automatic logic [INCR_BITS-1:0] byte_popcount(input logic [7:0] b);
      logic [INCR_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {{(INCR_BITS-1){1'b0}}, b[i]};
      end
      return n;
   endfunction

   function automatic logic [INCR_BITS-1:0] pattern_hits(input int k, input logic [7:0] b);
      logic [INCR_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_MASKS; i++) begin
         if ((i < int'(TUPLET_MASK_COUNT[k])) &&
             ((b & TUPLET_MASKS[k][i]) == TUPLET_MASKS[k][i])) begin
            n = n + {{(INCR_BITS-1){1'b0}}, 1'b1};
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sbtc_match.sv -----
// Pattern matcher: per-total increments for one sieve byte.
`default_nettype none

module sbtc_match (
   input  wire logic [7:0]            sieve_byte,
   output sbtc_pkg::sbtc_incr_type    incr
);
   import sbtc_pkg::*;

   always_comb begin
      incr = '0;
      incr[TOTAL_PRIME] = byte_popcount(sieve_byte);
      for (int k = TOTAL_TWIN; k < NUM_TOTALS; k++) begin
         incr[k] = pattern_hits(k, sieve_byte);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sbtc_accum.sv -----
// Saturating running totals, also serving as the result register.
`default_nettype none

module sbtc_accum (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire logic                                command,
   input  wire logic [sbtc_pkg::ENABLE_BITS-1:0]    count_enable,
   input  wire sbtc_pkg::sbtc_incr_type             incr,
   output sbtc_pkg::sbtc_rsp_type                   totals
);
   import sbtc_pkg::*;

   total_type totals_ff [NUM_TOTALS];
   total_type totals_in [NUM_TOTALS];
   logic [TOTAL_BITS:0] sum;

   always_comb begin
      sum = '0;
      for (int k = 0; k < NUM_TOTALS; k++) begin
         totals_in[k] = totals_ff[k];
         if (command == CMD_CLEAR) begin
            totals_in[k] = '0;
         end else if (count_enable[k]) begin
            sum = {1'b0, totals_ff[k]} + {{(TOTAL_BITS+1-INCR_BITS){1'b0}}, incr[k]};
            totals_in[k] = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TOTALS; k++) begin
            totals_ff[k] <= '0;
         end
      end else if (load) begin
         for (int k = 0; k < NUM_TOTALS; k++) begin
            totals_ff[k] <= totals_in[k];
         end
      end
   end

   assign totals.prime_total      = totals_ff[TOTAL_PRIME];
   assign totals.twin_total       = totals_ff[TOTAL_TWIN];
   assign totals.triplet_total    = totals_ff[TOTAL_TRIPLET];
   assign totals.quadruplet_total = totals_ff[TOTAL_QUADRUPLET];
   assign totals.quintuplet_total = totals_ff[TOTAL_QUINTUPLET];
   assign totals.sextuplet_total  = totals_ff[TOTAL_SEXTUPLET];

endmodule

`default_nettype wire

// ----- rtl/sieve_byte_tuplet_counter_unit.sv -----
// Top level of the sieve byte tuplet counter: handshake, enable register, datapath.
//
//  Channel | Direction | Handshake        | Carries
//  req     | in        | req_valid/stall  | command, sieve_byte
//  rsp     | out       | rsp_valid/stall  | six saturating totals
//  csr     | in        | csr_valid/ready  | count_enable (6 bits)
//
//  A request passes through the input register, then the totals register, to its result.
//  One transaction per cycle is sustained while rsp_stall is low; the totals update is combinational.
//  Reset clears totals to zero and count_enable to all ones; req_stall is high in reset.
//  A stalled result holds the totals; the input register then fills and req_stall rises.
`default_nettype none

module sieve_byte_tuplet_counter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire sbtc_pkg::sbtc_req_type              req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output sbtc_pkg::sbtc_rsp_type                   rsp_data,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [sbtc_pkg::ENABLE_BITS-1:0]    csr_data
);
   import sbtc_pkg::*;

   logic                   req_valid_ff;
   logic                   req_valid_in;
   sbtc_req_type           req_data_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [ENABLE_BITS-1:0] enable_ff;
   logic                   advance;
   logic                   req_fire;
   sbtc_incr_type          incr;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (req_valid_ff && rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_fire) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= ENABLE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_data_ff <= req_data;
      end
   end

   sbtc_match u_match (
      .sieve_byte (req_data_ff.sieve_byte),
      .incr       (incr)
   );

   sbtc_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .command      (req_data_ff.command),
      .count_enable (enable_ff),
      .incr         (incr),
      .totals       (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/sbtc_checker.sv -----
// Port-level checker for the sieve byte tuplet counter, bound to the top level.
`default_nettype none

module sbtc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire sbtc_pkg::sbtc_rsp_type rsp_data
);

   hold_stalled_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   result_follows_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a request two cycles earlier");

   totals_change_only_with_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(rsp_data) |-> rsp_valid)
      else $error("totals changed without a result");

   no_accept_in_reset: assert property (@(posedge clock)
      reset |-> req_stall)
      else $error("request accepted during reset");

endmodule

bind sieve_byte_tuplet_counter_unit sbtc_checker u_sbtc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the sieve byte tuplet counter: randomised stream with running-total prediction.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbtc_pkg::*;

   localparam logic [7:0] TUPLET_SHAPES [11] = '{
      8'h06, 8'h18, 8'hc0, 8'h07, 8'h0e, 8'h1c, 8'h38, 8'h1e, 8'h1f, 8'h3e, 8'h3f
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sbtc_req_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sbtc_rsp_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ENABLE_BITS-1:0] csr_data  = '0;

   sbtc_req_type pending_bytes [$];
   sbtc_rsp_type expected_totals [$];

   total_type              tally [NUM_TOTALS] = '{default: '0};
   logic [ENABLE_BITS-1:0] enable_shadow = ENABLE_RESET;

   bit idle_on    = 1'b1;
   bit drain_wait = 1'b0;
   int gap_left   = 0;
   int stall_left = 0;

   int adds_sent       = 0;
   int clears_sent     = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int settings_used   = 0;

   sieve_byte_tuplet_counter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [3:0] covers(input logic [7:0] b, input logic [7:0] shape);
      return ((b & shape) == shape) ? 4'd1 : 4'd0;
   endfunction

   function automatic sbtc_rsp_type advance_totals(input sbtc_req_type item);
      logic [3:0]         gain [NUM_TOTALS];
      logic [TOTAL_BITS:0] wide;
      logic [7:0]         b;
      sbtc_rsp_type       r;
      b = item.sieve_byte;
      gain[TOTAL_PRIME]      = 4'($countones(b));
      gain[TOTAL_TWIN]       = covers(b, 8'h06) + covers(b, 8'h18) + covers(b, 8'hc0);
      gain[TOTAL_TRIPLET]    = covers(b, 8'h07) + covers(b, 8'h0e) + covers(b, 8'h1c)
                             + covers(b, 8'h38);
      gain[TOTAL_QUADRUPLET] = covers(b, 8'h1e);
      gain[TOTAL_QUINTUPLET] = covers(b, 8'h1f) + covers(b, 8'h3e);
      gain[TOTAL_SEXTUPLET]  = covers(b, 8'h3f);
      for (int k = 0; k < NUM_TOTALS; k++) begin
         if (item.command == CMD_CLEAR) begin
            tally[k] = '0;
         end else if (enable_shadow[k]) begin
            wide = {1'b0, tally[k]} + {{(TOTAL_BITS-3){1'b0}}, gain[k]};
            tally[k] = wide[TOTAL_BITS] ? '1 : wide[TOTAL_BITS-1:0];
         end
      end
      r.prime_total      = tally[TOTAL_PRIME];
      r.twin_total       = tally[TOTAL_TWIN];
      r.triplet_total    = tally[TOTAL_TRIPLET];
      r.quadruplet_total = tally[TOTAL_QUADRUPLET];
      r.quintuplet_total = tally[TOTAL_QUINTUPLET];
      r.sextuplet_total  = tally[TOTAL_SEXTUPLET];
      return r;
   endfunction

   task automatic show_field(input string name, input total_type want, input total_type got);
      if (want !== got) begin
         $display("   %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_totals.push_back(advance_totals(req_data));
            if (req_data.command == CMD_CLEAR) begin
               clears_sent++;
            end else begin
               adds_sent++;
            end
         end
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (drain_wait) begin
            req_valid <= 1'b0;
            if (expected_totals.size() == 0 && !req_valid) begin
               drain_wait = 1'b0;
            end
         end else if (pending_bytes.size() != 0) begin
            req_data  <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            gap_left   = idle_on ? pick_gap() : 0;
            if ($urandom_range(0, 149) == 0) begin
               drain_wait = 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sbtc_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            enable_shadow <= csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result transaction: prime %0d twin %0d",
                           rsp_data.prime_total, rsp_data.twin_total);
               end
            end else begin
               want = expected_totals.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch on result %0d", results_checked);
                     show_field("prime_total", want.prime_total, rsp_data.prime_total);
                     show_field("twin_total", want.twin_total, rsp_data.twin_total);
                     show_field("triplet_total", want.triplet_total, rsp_data.triplet_total);
                     show_field("quadruplet_total", want.quadruplet_total,
                                rsp_data.quadruplet_total);
                     show_field("quintuplet_total", want.quintuplet_total,
                                rsp_data.quintuplet_total);
                     show_field("sextuplet_total", want.sextuplet_total,
                                rsp_data.sextuplet_total);
                  end
               end
               results_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 5) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_totals.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_enable(input logic [ENABLE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic push_item(input logic command, input logic [7:0] sieve_byte);
      sbtc_req_type item;
      item.command    = command;
      item.sieve_byte = sieve_byte;
      pending_bytes.push_back(item);
   endtask

   task automatic run_phase(input logic [ENABLE_BITS-1:0] enable, input int count,
                            input bit idling);
      int r;
      write_enable(enable);
      idle_on = idling;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            push_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
         end else if (r < 45) begin
            push_item(CMD_ADD, TUPLET_SHAPES[$urandom_range(0, 10)] | 8'($urandom & $urandom));
         end else begin
            push_item(CMD_ADD, 8'($urandom_range(0, 255)));
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_enable(ENABLE_RESET);
      push_item(CMD_ADD, 8'h00);
      push_item(CMD_ADD, 8'hff);
      foreach (TUPLET_SHAPES[i]) begin
         push_item(CMD_ADD, TUPLET_SHAPES[i]);
      end
      push_item(CMD_ADD, 8'h01);
      push_item(CMD_ADD, 8'h80);
      push_item(CMD_ADD, 8'haa);
      push_item(CMD_ADD, 8'h55);
      push_item(CMD_CLEAR, 8'hff);
      push_item(CMD_ADD, 8'hde);
      push_item(CMD_CLEAR, 8'h00);
      push_item(CMD_ADD, 8'hff);
      wait_drained();

      run_phase(6'h00, 140, 1'b1);
      run_phase(6'h3f, 160, 1'b0);
      run_phase(6'h01, 140, 1'b1);
      run_phase(6'h2a, 150, 1'b1);
      run_phase(6'h15, 150, 1'b0);
      run_phase(6'($urandom_range(0, 63)), 150, 1'b1);
      run_phase(6'h20, 140, 1'b1);
      run_phase(6'($urandom_range(0, 63)), 150, 1'b1);
      run_phase(6'h3f, 150, 1'b1);

      mismatches += expected_totals.size();
      $display("covered %0d add and %0d clear transactions under %0d enable settings,",
               adds_sent, clears_sent, settings_used);
      $display("with %0d result transactions checked against the running totals", results_checked);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_totals.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/sbtc_pkg.sv
rtl/sbtc_match.sv
rtl/sbtc_accum.sv
rtl/sieve_byte_tuplet_counter_unit.sv
rtl/sbtc_checker.sv
tb/sv/tb.sv
